// File: src/sof_pkg.sv
// Shared constants, register codes, pipeline sideband type and sine table builder
// for the sphere overlap filter. No dependencies.
package sof_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam logic [63:0] PIH_Q30 = 64'd1686629713;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_MASK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ID    = 3'd5;

  localparam logic [31:0] LAYER_MASK_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        valid;
    logic        pass;
    logic        is_box;
    logic [31:0] id;
  } side_t;

  // First-quadrant sine, Q30 series at x (Q30 radians), rounded to frac bits.
  function automatic logic [31:0] quarter_sin(input logic [63:0] x, input int frac);
    logic        [63:0] x2;
    logic        [63:0] term;
    logic        [63:0] prod;
    logic signed [63:0] sum;
    logic        [63:0] rnd;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if ((n & 1) != 0) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    rnd = 64'(sum) + (64'd1 << (29 - frac));
    return 32'(rnd >> (30 - frac));
  endfunction

endpackage

// File: src/sof_angle.sv
// Angle reduction and sine/cosine table lookup, three register stages.
// Depends on sof_pkg.
module sof_angle #(
  parameter int FRAC_BITS        = sof_pkg::FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = sof_pkg::SINE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [31:0]         rot [3],
  output logic signed [FRAC_BITS+1:0] sn [3],
  output logic signed [FRAC_BITS+1:0] cs [3]
);

  localparam int SW    = FRAC_BITS + 2;
  localparam int IDXW  = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR   = SINE_TABLE_DEPTH / 4;
  localparam int QW    = IDXW - 1;
  localparam int YW    = 33 + IDXW;
  localparam int MW    = 32 + IDXW - FRAC_BITS;
  localparam int SFT   = MW + 9;
  localparam int PRW   = 2 * MW + 1;
  localparam logic [MW:0] RECIP = (MW+1)'(((64'd1 << SFT) + 64'd359) / 64'd360);

  logic [FRAC_BITS:0] qtab [0:QTR];

  for (genvar k = 0; k <= QTR; k++) begin : g_tab
    localparam logic [63:0] XK = (sof_pkg::PIH_Q30 * 64'(k)) / 64'(QTR);
    assign qtab[k] = (FRAC_BITS+1)'(sof_pkg::quarter_sin(XK, FRAC_BITS));
  end

  function automatic logic signed [SW-1:0] rom_sin(input logic [IDXW-1:0] i);
    logic [QW-1:0]      r;
    logic [FRAC_BITS:0] v;
    r = {1'b0, i[IDXW-3:0]};
    v = i[IDXW-2] ? qtab[QW'(QTR) - r] : qtab[r];
    return i[IDXW-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  logic signed [YW-1:0] y    [3];
  logic        [YW-1:0] ym   [3];
  logic        [MW-1:0] mp   [3];
  logic        [MW-1:0] mp_r [3];
  logic                 neg1_r [3];
  logic        [PRW-1:0] prod_r [3];
  logic                 neg2_r [3];
  logic       [IDXW-1:0] q     [3];
  logic       [IDXW-1:0] idx   [3];
  logic signed [SW-1:0] sn_r  [3];
  logic signed [SW-1:0] cs_r  [3];

  // floor((ang*D + 180deg)/360deg) mod D, floor division via reciprocal on magnitude
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      y[j]  = (YW'(rot[j]) <<< IDXW) >>> FRAC_BITS;
      y[j]  = y[j] + YW'(180);
      ym[j] = y[j][YW-1] ? YW'(-y[j]) : YW'(y[j]);
      mp[j] = y[j][YW-1] ? MW'(ym[j]) + MW'(359) : MW'(ym[j]);
      q[j]  = prod_r[j][SFT +: IDXW];
      idx[j] = neg2_r[j] ? IDXW'(-q[j]) : q[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mp_r[j]   <= mp[j];
        neg1_r[j] <= y[j][YW-1];
        prod_r[j] <= PRW'(mp_r[j]) * PRW'(RECIP);
        neg2_r[j] <= neg1_r[j];
        sn_r[j]   <= rom_sin(idx[j]);
        cs_r[j]   <= rom_sin(idx[j] + IDXW'(QTR));
      end
    end
  end

  assign sn = sn_r;
  assign cs = cs_r;

endmodule

// File: src/sof_rot.sv
// Rotation matrix Rz*Ry*Rx from sines and cosines, two register stages.
// Depends on sof_pkg.
module sof_rot #(
  parameter int FRAC_BITS = sof_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] sn [3],
  input  logic signed [FRAC_BITS+1:0] cs [3],
  output logic signed [FRAC_BITS+2:0] ax [3][3]
);

  localparam int SW  = FRAC_BITS + 2;
  localparam int AXW = SW + 1;

  function automatic logic signed [SW-1:0] fmul(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] pr;
    logic        [2*SW-1:0] m;
    logic        [2*SW-1:0] r;
    pr = a * b;
    m  = pr[2*SW-1] ? (2*SW)'(-pr) : (2*SW)'(pr);
    r  = (m + ((2*SW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return pr[2*SW-1] ? $signed(-SW'(r)) : $signed(SW'(r));
  endfunction

  logic signed [SW-1:0] s0s1_r, c0s1_r, c1c2_r, c1s2_r, s0c1_r, c0c1_r;
  logic signed [SW-1:0] c0s2_r, c0c2_r, s0s2_r, s0c2_r, s1_r, s2_r, c2_r;
  logic signed [AXW-1:0] ax_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      s0s1_r <= fmul(sn[0], sn[1]);
      c0s1_r <= fmul(cs[0], sn[1]);
      c1c2_r <= fmul(cs[1], cs[2]);
      c1s2_r <= fmul(cs[1], sn[2]);
      s0c1_r <= fmul(sn[0], cs[1]);
      c0c1_r <= fmul(cs[0], cs[1]);
      c0s2_r <= fmul(cs[0], sn[2]);
      c0c2_r <= fmul(cs[0], cs[2]);
      s0s2_r <= fmul(sn[0], sn[2]);
      s0c2_r <= fmul(sn[0], cs[2]);
      s1_r   <= sn[1];
      s2_r   <= sn[2];
      c2_r   <= cs[2];

      ax_r[0][0] <= AXW'(c1c2_r);
      ax_r[0][1] <= AXW'(c1s2_r);
      ax_r[0][2] <= -AXW'(s1_r);
      ax_r[1][0] <= AXW'(fmul(s0s1_r, c2_r)) - AXW'(c0s2_r);
      ax_r[1][1] <= AXW'(fmul(s0s1_r, s2_r)) + AXW'(c0c2_r);
      ax_r[1][2] <= AXW'(s0c1_r);
      ax_r[2][0] <= AXW'(fmul(c0s1_r, c2_r)) + AXW'(s0s2_r);
      ax_r[2][1] <= AXW'(fmul(c0s1_r, s2_r)) - AXW'(s0c2_r);
      ax_r[2][2] <= AXW'(c0c1_r);
    end
  end

  assign ax = ax_r;

endmodule

// File: src/sof_sphere.sv
// Sphere collider test: squared center distance against squared radius sum.
// Three register stages. No dependencies.
module sof_sphere (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] dl [3],
  input  logic signed [31:0] radius,
  input  logic        [30:0] qr,
  output logic               hit
);

  logic        [32:0] m_r [3];
  logic        [32:0] comb_r;
  logic signed [32:0] sum;
  logic        [65:0] sq_r [3];
  logic        [65:0] comb2_r;
  logic        [67:0] acc;
  logic               hit_r;

  always_comb begin
    sum = 33'(radius) + 33'({2'b00, qr});
    acc = 68'(sq_r[0]) + 68'(sq_r[1]) + 68'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k]  <= dl[k][32] ? 33'(-dl[k]) : 33'(dl[k]);
        sq_r[k] <= 66'(m_r[k]) * 66'(m_r[k]);
      end
      comb_r  <= sum[32] ? 33'(-sum) : 33'(sum);
      comb2_r <= 66'(comb_r) * 66'(comb_r);
      hit_r   <= acc <= 68'(comb2_r);
    end
  end

  assign hit = hit_r;

endmodule

// File: src/sof_box.sv
// Oriented box test: axis projections, clamp to extents, closest-point distance.
// Seven register stages. Depends on sof_pkg.
module sof_box #(
  parameter int FRAC_BITS = sof_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+2:0] ax  [3][3],
  input  logic signed [32:0]          dl  [3],
  input  logic        [31:0]          ext [3],
  input  logic        [61:0]          qr2,
  output logic                        hit
);

  localparam int AXW  = FRAC_BITS + 3;
  localparam int PW   = 33 + AXW;
  localparam int DW   = PW + 2;
  localparam int OPW  = AXW + 33;
  localparam int OW   = OPW + 2;
  localparam int EW   = OW + 1;
  localparam int EMW  = EW + 1 - FRAC_BITS;
  localparam int HALF = EMW / 2;
  localparam int HI   = EMW - HALF;
  localparam int SQW  = 2 * EMW;
  localparam int ACW  = SQW + 2;

  logic signed [PW-1:0]  dp_r   [3][3];
  logic signed [AXW-1:0] ax_b1_r [3][3];
  logic signed [AXW-1:0] ax_b2_r [3][3];
  logic signed [32:0]    dl_b1_r [3];
  logic signed [32:0]    dl_b2_r [3];
  logic signed [32:0]    dl_b3_r [3];
  logic        [31:0]    ext_b1_r [3];
  logic signed [DW-1:0]  dsum [3];
  logic        [DW-1:0]  dmag [3];
  logic        [DW-1:0]  rr   [3];
  logic        [31:0]    pm   [3];
  logic signed [32:0]    p    [3];
  logic signed [32:0]    p_r  [3];
  logic signed [OPW-1:0] op_r [3][3];
  logic signed [OW-1:0]  off  [3];
  logic signed [EW-1:0]  diff [3];
  logic        [EW-1:0]  emag [3];
  logic        [EW:0]    ernd [3];
  logic        [EMW-1:0] e_r  [3];
  logic        [2*HALF-1:0] ll_r [3];
  logic        [2*HALF-1:0] lh_r [3];
  logic        [2*HI-1:0]   hh_r [3];
  logic        [SQW-1:0] sq_r [3];
  logic        [ACW-1:0] acc;
  logic                  hit_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dsum[j] = DW'(dp_r[j][0]) + DW'(dp_r[j][1]) + DW'(dp_r[j][2]);
      dmag[j] = dsum[j][DW-1] ? DW'(-dsum[j]) : DW'(dsum[j]);
      rr[j]   = (dmag[j] + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      // zero extent clamps to zero, which skips the axis
      pm[j]   = (rr[j] > DW'(ext_b1_r[j])) ? ext_b1_r[j] : rr[j][31:0];
      p[j]    = dsum[j][DW-1] ? -$signed({1'b0, pm[j]}) : $signed({1'b0, pm[j]});
    end
    for (int k = 0; k < 3; k++) begin
      off[k]  = OW'(op_r[0][k]) + OW'(op_r[1][k]) + OW'(op_r[2][k]);
      diff[k] = (EW'(dl_b3_r[k]) <<< FRAC_BITS) - EW'(off[k]);
      emag[k] = diff[k][EW-1] ? EW'(-diff[k]) : EW'(diff[k]);
      ernd[k] = (EW+1)'(emag[k]) + ((EW+1)'(1) << (FRAC_BITS - 1));
    end
    acc = ACW'(sq_r[0]) + ACW'(sq_r[1]) + ACW'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          dp_r[j][k]    <= PW'(dl[k]) * PW'(ax[j][k]);
          ax_b1_r[j][k] <= ax[j][k];
          ax_b2_r[j][k] <= ax_b1_r[j][k];
          op_r[j][k]    <= OPW'(ax_b2_r[j][k]) * OPW'(p_r[j]);
        end
        ext_b1_r[j] <= ext[j];
        p_r[j]      <= p[j];
      end
      for (int k = 0; k < 3; k++) begin
        dl_b1_r[k] <= dl[k];
        dl_b2_r[k] <= dl_b1_r[k];
        dl_b3_r[k] <= dl_b2_r[k];
        e_r[k]     <= ernd[k][EW:FRAC_BITS];
        ll_r[k]    <= (2*HALF)'(e_r[k][HALF-1:0]) * (2*HALF)'(e_r[k][HALF-1:0]);
        lh_r[k]    <= (2*HALF)'(e_r[k][HALF-1:0]) * (2*HALF)'(e_r[k][EMW-1:HALF]);
        hh_r[k]    <= (2*HI)'(e_r[k][EMW-1:HALF]) * (2*HI)'(e_r[k][EMW-1:HALF]);
        sq_r[k]    <= (SQW'(hh_r[k]) << (2 * HALF)) + (SQW'(lh_r[k]) << (HALF + 1))
                      + SQW'(ll_r[k]);
      end
      hit_r <= acc <= ACW'(qr2);
    end
  end

  assign hit = hit_r;

endmodule

// File: src/sphere_overlap_filter_top.sv
// Sphere overlap filter top level: config registers, input stage, sideband delay
// lines and result register. Depends on sof_pkg, sof_angle, sof_rot, sof_sphere, sof_box.
//
// Takes one collider beat per clock unless stalled and returns its object id when the
// collider passes the id and layer filters and overlaps the query sphere. Results come
// out in order; colliders that miss produce no beat. The datapath is a fixed 13-stage
// pipeline behind a result register, and a stall on the result side while a result is
// valid holds the whole pipeline (in_stall follows it the same cycle). SINE_TABLE_DEPTH
// must be a power of two; the sine table holds one quarter turn, SINE_TABLE_DEPTH/4+1
// entries. Registers may be written only when no beat is in flight.
module sphere_overlap_filter_top #(
  parameter int FRAC_BITS        = sof_pkg::FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = sof_pkg::SINE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sof_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sof_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_is_box,
  input  logic [31:0]                      in_object_id,
  input  logic [4:0]                       in_layer,
  input  logic signed [31:0]               in_pos_x,
  input  logic signed [31:0]               in_pos_y,
  input  logic signed [31:0]               in_pos_z,
  input  logic signed [31:0]               in_rot_x,
  input  logic signed [31:0]               in_rot_y,
  input  logic signed [31:0]               in_rot_z,
  input  logic signed [31:0]               in_scale_x,
  input  logic signed [31:0]               in_scale_y,
  input  logic signed [31:0]               in_scale_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_hit_id
);

  localparam int SW   = FRAC_BITS + 2;
  localparam int AXW  = FRAC_BITS + 3;
  localparam int SIDE_LAT = 12;
  localparam int GEO_LAT  = 5;
  localparam int SPH_LAT  = 9;

  logic signed [31:0] center_x_r, center_y_r, center_z_r;
  logic        [30:0] query_radius_r;
  logic        [31:0] layer_mask_r, ignore_id_r;
  logic        [61:0] qr2_r;

  logic               en;
  logic               v1_r;
  logic               is_box1_r;
  logic        [31:0] id1_r;
  logic        [4:0]  layer1_r;
  logic signed [31:0] pos1_r [3];
  logic signed [31:0] rot1_r [3];
  logic signed [31:0] scl1_r [3];

  logic signed [32:0] dl1  [3];
  logic        [31:0] ext1 [3];
  sof_pkg::side_t     side1;
  sof_pkg::side_t     side_r [SIDE_LAT];
  sof_pkg::side_t     side_o;
  logic signed [32:0] dl_d_r  [GEO_LAT][3];
  logic        [31:0] ext_d_r [GEO_LAT][3];
  logic               sph_hit;
  logic               sph_d_r [SPH_LAT];
  logic               box_hit;

  logic signed [SW-1:0]  sn [3];
  logic signed [SW-1:0]  cs [3];
  logic signed [AXW-1:0] ax [3][3];

  logic               out_valid_r;
  logic        [31:0] out_hit_id_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      center_z_r     <= '0;
      query_radius_r <= '0;
      layer_mask_r   <= sof_pkg::LAYER_MASK_RST;
      ignore_id_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sof_pkg::REG_CENTER_X:     center_x_r     <= $signed(cfg_wdata);
        sof_pkg::REG_CENTER_Y:     center_y_r     <= $signed(cfg_wdata);
        sof_pkg::REG_CENTER_Z:     center_z_r     <= $signed(cfg_wdata);
        sof_pkg::REG_QUERY_RADIUS: query_radius_r <= cfg_wdata[30:0];
        sof_pkg::REG_LAYER_MASK:   layer_mask_r   <= cfg_wdata;
        sof_pkg::REG_IGNORE_ID:    ignore_id_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    qr2_r <= 62'(query_radius_r) * 62'(query_radius_r);
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_box1_r <= in_is_box;
      id1_r     <= in_object_id;
      layer1_r  <= in_layer;
      pos1_r[0] <= in_pos_x;
      pos1_r[1] <= in_pos_y;
      pos1_r[2] <= in_pos_z;
      rot1_r[0] <= in_rot_x;
      rot1_r[1] <= in_rot_y;
      rot1_r[2] <= in_rot_z;
      scl1_r[0] <= in_scale_x;
      scl1_r[1] <= in_scale_y;
      scl1_r[2] <= in_scale_z;
    end
  end

  always_comb begin
    dl1[0] = 33'(center_x_r) - 33'(pos1_r[0]);
    dl1[1] = 33'(center_y_r) - 33'(pos1_r[1]);
    dl1[2] = 33'(center_z_r) - 33'(pos1_r[2]);
    for (int j = 0; j < 3; j++) begin
      ext1[j] = scl1_r[j][31] ? 32'(-scl1_r[j]) : 32'(scl1_r[j]);
    end
    side1.valid  = v1_r;
    side1.pass   = !((ignore_id_r != '0) && (id1_r == ignore_id_r)) && layer_mask_r[layer1_r];
    side1.is_box = is_box1_r;
    side1.id     = id1_r;
  end

  // sideband delay lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_LAT; i++) side_r[i].valid <= 1'b0;
    end else if (en) begin
      side_r[0].valid <= side1.valid;
      for (int i = 1; i < SIDE_LAT; i++) side_r[i].valid <= side_r[i-1].valid;
    end
    if (en) begin
      side_r[0].pass   <= side1.pass;
      side_r[0].is_box <= side1.is_box;
      side_r[0].id     <= side1.id;
      for (int i = 1; i < SIDE_LAT; i++) begin
        side_r[i].pass   <= side_r[i-1].pass;
        side_r[i].is_box <= side_r[i-1].is_box;
        side_r[i].id     <= side_r[i-1].id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dl_d_r[0][k]  <= dl1[k];
        ext_d_r[0][k] <= ext1[k];
        for (int i = 1; i < GEO_LAT; i++) begin
          dl_d_r[i][k]  <= dl_d_r[i-1][k];
          ext_d_r[i][k] <= ext_d_r[i-1][k];
        end
      end
      sph_d_r[0] <= sph_hit;
      for (int i = 1; i < SPH_LAT; i++) sph_d_r[i] <= sph_d_r[i-1];
    end
  end

  sof_angle #(
    .FRAC_BITS        (FRAC_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_angle (
    .clk (clk),
    .en  (en),
    .rot (rot1_r),
    .sn  (sn),
    .cs  (cs)
  );

  sof_rot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rot (
    .clk (clk),
    .en  (en),
    .sn  (sn),
    .cs  (cs),
    .ax  (ax)
  );

  sof_sphere u_sphere (
    .clk    (clk),
    .en     (en),
    .dl     (dl1),
    .radius (scl1_r[0]),
    .qr     (query_radius_r),
    .hit    (sph_hit)
  );

  sof_box #(
    .FRAC_BITS (FRAC_BITS)
  ) u_box (
    .clk (clk),
    .en  (en),
    .ax  (ax),
    .dl  (dl_d_r[GEO_LAT-1]),
    .ext (ext_d_r[GEO_LAT-1]),
    .qr2 (qr2_r),
    .hit (box_hit)
  );

  assign side_o = side_r[SIDE_LAT-1];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= side_o.valid && side_o.pass &&
                     (side_o.is_box ? box_hit : sph_d_r[SPH_LAT-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_hit_id_r <= side_o.id;
  end

  assign out_valid  = out_valid_r;
  assign out_hit_id = out_hit_id_r;

  a_bubble_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !side_o.valid) |=> !out_valid_r)
    else $error("result beat from an empty pipeline slot");

  a_filtered_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (en && side_o.valid && !side_o.pass) |=> !out_valid_r)
    else $error("result beat for a filtered collider");

  a_ignore_respected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ignore_id_r != '0)) |-> (out_hit_id_r != ignore_id_r))
    else $error("ignored id reported as hit");

endmodule

// File: sim/sof_checker.sv
// Scoreboard for the sphere overlap filter: mirrors the config registers, predicts
// the hit id of every accepted collider beat and compares result beats in order.
// Depends on sof_pkg.
module sof_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sof_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sof_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_is_box,
  input  logic [31:0]                    in_object_id,
  input  logic [4:0]                     in_layer,
  input  logic signed [31:0]             in_pos_x,
  input  logic signed [31:0]             in_pos_y,
  input  logic signed [31:0]             in_pos_z,
  input  logic signed [31:0]             in_rot_x,
  input  logic signed [31:0]             in_rot_y,
  input  logic signed [31:0]             in_rot_z,
  input  logic signed [31:0]             in_scale_x,
  input  logic signed [31:0]             in_scale_y,
  input  logic signed [31:0]             in_scale_z,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [31:0]                    out_hit_id,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FB        = 16;
  localparam int     DEPTH     = 1024;
  localparam int     QTR       = DEPTH / 4;
  localparam longint FULL_TURN = 64'd360 << FB;

  longint            sine_q [0:QTR];
  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0]       radius;
  logic [31:0]       layer_en;
  logic [31:0]       skip_id;
  logic [31:0]       hit_q [$];

  function automatic longint quadrant_sine(input int k);
    logic [63:0] x, x2, term;
    longint      sum;
    x    = (sof_pkg::PIH_Q30 * 64'(k)) / 64'(QTR);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return (sum + (64'd1 << (29 - FB))) >>> (30 - FB);
  endfunction

  initial begin
    for (int k = 0; k <= QTR; k++) sine_q[k] = quadrant_sine(k);
  end

  function automatic longint sine_at(input int i);
    int q, r;
    i = i % DEPTH;
    q = i / QTR;
    r = i % QTR;
    case (q)
      0: return sine_q[r];
      1: return sine_q[QTR - r];
      2: return -sine_q[r];
      default: return -sine_q[QTR - r];
    endcase
  endfunction

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint round_shift(input longint v);
    longint m;
    m = (abs64(v) + (64'd1 << (FB - 1))) >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint fmul(input longint a, input longint b);
    return round_shift(a * b);
  endfunction

  function automatic int angle_to_index(input longint ang);
    longint a;
    a = ang % FULL_TURN;
    if (a < 0) a = a + FULL_TURN;
    return int'(((a * DEPTH + FULL_TURN / 2) / FULL_TURN) % DEPTH);
  endfunction

  function automatic logic [127:0] square128(input longint v);
    logic [63:0] u;
    u = 64'(abs64(v));
    return {64'd0, u} * {64'd0, u};
  endfunction

  function automatic bit box_overlaps(input longint dx, input longint dy, input longint dz,
                                      input longint ax_, input longint ay_, input longint az_,
                                      input longint ex, input longint ey, input longint ez);
    longint       sn [3], cs [3], rm [3][3], dl [3], off [3], ang [3], ext [3];
    longint       d, p;
    logic [127:0] acc;
    int           idx;
    dl[0] = dx;  dl[1] = dy;  dl[2] = dz;
    ang[0] = ax_; ang[1] = ay_; ang[2] = az_;
    ext[0] = abs64(ex); ext[1] = abs64(ey); ext[2] = abs64(ez);
    for (int j = 0; j < 3; j++) begin
      idx = angle_to_index(ang[j]);
      sn[j] = sine_at(idx);
      cs[j] = sine_at(idx + QTR);
      off[j] = 0;
    end
    rm[0][0] = fmul(cs[1], cs[2]);
    rm[0][1] = fmul(cs[1], sn[2]);
    rm[0][2] = -sn[1];
    rm[1][0] = fmul(fmul(sn[0], sn[1]), cs[2]) - fmul(cs[0], sn[2]);
    rm[1][1] = fmul(fmul(sn[0], sn[1]), sn[2]) + fmul(cs[0], cs[2]);
    rm[1][2] = fmul(sn[0], cs[1]);
    rm[2][0] = fmul(fmul(cs[0], sn[1]), cs[2]) + fmul(sn[0], sn[2]);
    rm[2][1] = fmul(fmul(cs[0], sn[1]), sn[2]) - fmul(sn[0], cs[2]);
    rm[2][2] = fmul(cs[0], cs[1]);
    for (int j = 0; j < 3; j++) begin
      if (ext[j] != 0) begin
        d = 0;
        for (int k = 0; k < 3; k++) d = d + dl[k] * rm[j][k];
        p = round_shift(d);
        if (p > ext[j]) p = ext[j];
        if (p < -ext[j]) p = -ext[j];
        for (int k = 0; k < 3; k++) off[k] = off[k] + rm[j][k] * p;
      end
    end
    acc = '0;
    for (int k = 0; k < 3; k++) acc = acc + square128(round_shift((dl[k] <<< FB) - off[k]));
    return acc <= square128(longint'(radius));
  endfunction

  function automatic bit collider_hits();
    longint dx, dy, dz;
    logic [127:0] acc;
    if (skip_id != 0 && in_object_id == skip_id) return 1'b0;
    if (!layer_en[in_layer]) return 1'b0;
    dx = longint'(ctr_x) - longint'(in_pos_x);
    dy = longint'(ctr_y) - longint'(in_pos_y);
    dz = longint'(ctr_z) - longint'(in_pos_z);
    if (in_is_box)
      return box_overlaps(dx, dy, dz, longint'(in_rot_x), longint'(in_rot_y),
                          longint'(in_rot_z), longint'(in_scale_x), longint'(in_scale_y),
                          longint'(in_scale_z));
    acc = square128(dx) + square128(dy) + square128(dz);
    return acc <= square128(longint'(in_scale_x) + longint'(radius));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ctr_x    <= '0;
      ctr_y    <= '0;
      ctr_z    <= '0;
      radius   <= '0;
      layer_en <= sof_pkg::LAYER_MASK_RST;
      skip_id  <= '0;
      hit_q.delete();
      errors   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sof_pkg::REG_CENTER_X:     ctr_x    <= cfg_wdata;
          sof_pkg::REG_CENTER_Y:     ctr_y    <= cfg_wdata;
          sof_pkg::REG_CENTER_Z:     ctr_z    <= cfg_wdata;
          sof_pkg::REG_QUERY_RADIUS: radius   <= cfg_wdata[30:0];
          sof_pkg::REG_LAYER_MASK:   layer_en <= cfg_wdata;
          sof_pkg::REG_IGNORE_ID:    skip_id  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall && collider_hits()) hit_q = {hit_q, in_object_id};
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          $error("hit_id expected none got %h", out_hit_id);
          errors <= errors + 1;
        end else begin
          if (out_hit_id !== hit_q[0]) begin
            $error("hit_id expected %h got %h", hit_q[0], out_hit_id);
            errors <= errors + 1;
          end
          void'(hit_q.pop_front());
        end
      end
    end
    pending <= hit_q.size();
  end

  initial pending = 0;

endmodule

// File: sim/sphere_overlap_filter_top_tb.sv
// Top of the sphere overlap filter testbench: clock, reset, config writes, collider
// stimulus, result-side stalls and the verdict. Depends on sof_pkg, sof_checker, the RTL.
module sphere_overlap_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] DEG = 32'h0001_0000;

  typedef struct {
    logic              is_box;
    logic [31:0]       id;
    logic [4:0]        layer;
    logic signed [31:0] pos [3];
    logic signed [31:0] rot [3];
    logic signed [31:0] scl [3];
  } collider_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [sof_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sof_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_is_box = 1'b0;
  logic [31:0]                    in_object_id = '0;
  logic [4:0]                     in_layer = '0;
  logic signed [31:0]             in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0]             in_rot_x = '0, in_rot_y = '0, in_rot_z = '0;
  logic signed [31:0]             in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [31:0]                    out_hit_id;
  int                             errors, pending;
  int                             idle_pct = 0, stall_pct = 0;
  bit                             drain = 1'b0;
  logic signed [31:0]             ctr [3];
  logic [30:0]                    radius;
  logic [31:0]                    skip_id;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sphere_overlap_filter_top u_dut (.*);

  sof_checker u_checker (.*);

  always @(posedge clk) out_stall <= !drain && ($urandom_range(99) < stall_pct);

  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [sof_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    drain = 1'b1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    drain = 1'b0;
  endtask

  task automatic set_query(input logic signed [31:0] cx, input logic signed [31:0] cy,
                           input logic signed [31:0] cz, input logic [30:0] r,
                           input logic [31:0] mask, input logic [31:0] skip);
    drain_pipe();
    ctr[0] = cx; ctr[1] = cy; ctr[2] = cz; radius = r; skip_id = skip;
    write_reg(sof_pkg::REG_CENTER_X, cx);
    write_reg(sof_pkg::REG_CENTER_Y, cy);
    write_reg(sof_pkg::REG_CENTER_Z, cz);
    write_reg(sof_pkg::REG_QUERY_RADIUS, {1'b0, r});
    write_reg(sof_pkg::REG_LAYER_MASK, mask);
    write_reg(sof_pkg::REG_IGNORE_ID, skip);
  endtask

  task automatic send(input collider_t c);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_is_box    <= c.is_box;
    in_object_id <= c.id;
    in_layer     <= c.layer;
    in_pos_x     <= c.pos[0];
    in_pos_y     <= c.pos[1];
    in_pos_z     <= c.pos[2];
    in_rot_x     <= c.rot[0];
    in_rot_y     <= c.rot[1];
    in_rot_z     <= c.rot[2];
    in_scale_x   <= c.scl[0];
    in_scale_y   <= c.scl[1];
    in_scale_z   <= c.scl[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic collider_t make_collider(input bit box, input logic [31:0] id,
                                              input logic signed [31:0] p0,
                                              input logic signed [31:0] p1,
                                              input logic signed [31:0] p2,
                                              input logic signed [31:0] r0,
                                              input logic signed [31:0] r1,
                                              input logic signed [31:0] r2,
                                              input logic signed [31:0] s0,
                                              input logic signed [31:0] s1,
                                              input logic signed [31:0] s2);
    collider_t c;
    c.is_box = box; c.id = id; c.layer = 5'(id);
    c.pos[0] = p0; c.pos[1] = p1; c.pos[2] = p2;
    c.rot[0] = r0; c.rot[1] = r1; c.rot[2] = r2;
    c.scl[0] = s0; c.scl[1] = s1; c.scl[2] = s2;
    return c;
  endfunction

  // Mostly colliders placed around the query sphere; some fully random noise.
  function automatic collider_t random_collider();
    collider_t c;
    int        span;
    c.is_box = 1'($urandom_range(1));
    c.id     = ($urandom_range(9) == 0) ? skip_id : $urandom;
    c.layer  = 5'($urandom);
    if ($urandom_range(9) == 0) begin
      for (int k = 0; k < 3; k++) begin
        c.pos[k] = $urandom; c.rot[k] = $urandom; c.scl[k] = $urandom;
      end
    end else begin
      span = (radius > 31'd1 << 28) ? (1 << 29) : int'(radius) * 2 + 1;
      for (int k = 0; k < 3; k++) begin
        c.pos[k] = ctr[k] + $signed($urandom_range(2 * span)) - span;
        c.rot[k] = ($urandom_range(3) == 0) ? $urandom
                                            : $signed($urandom_range(720 << 16)) - (360 << 16);
        c.scl[k] = ($urandom_range(7) == 0) ? 0 : $signed($urandom_range(span)) - span / 4;
      end
    end
    return c;
  endfunction

  initial begin
    collider_t c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    ctr[0] = 0; ctr[1] = 0; ctr[2] = 0; radius = 0; skip_id = 0;

    // reset settings: zero radius, id 0 not skipped
    send(make_collider(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(make_collider(1, 32'd7, 0, 0, 0, 45 * DEG, 0, 0, DEG, DEG, DEG));
    send(make_collider(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send(make_collider(1, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));

    set_query(5 * DEG, -3 * DEG, 2 * DEG, 31'(2 * DEG), 32'hFFFF_FFFE, 32'd9);
    send(make_collider(0, 32'd33, 8 * DEG, -3 * DEG, 2 * DEG, 0, 0, 0, DEG, 0, 0));
    send(make_collider(0, 32'd34, 9 * DEG, -3 * DEG, 2 * DEG, 0, 0, 0, DEG, 0, 0));
    send(make_collider(0, 32'd35, 5 * DEG, -3 * DEG, 2 * DEG, 0, 0, 0, -5 * DEG, 0, 0));
    send(make_collider(0, 32'd9, 5 * DEG, -3 * DEG, 2 * DEG, 0, 0, 0, DEG, 0, 0));
    send(make_collider(0, 32'd32, 5 * DEG, -3 * DEG, 2 * DEG, 0, 0, 0, DEG, 0, 0));
    send(make_collider(1, 32'd37, 9 * DEG, -3 * DEG, 2 * DEG, 0, 0, 90 * DEG,
                       3 * DEG, DEG, DEG));
    send(make_collider(1, 32'd38, 9 * DEG, -3 * DEG, 2 * DEG, -30 * DEG, 45 * DEG,
                       -720 * DEG, 0, -DEG, 0));
    send(make_collider(1, 32'd39, 9 * DEG, -2 * DEG, 3 * DEG, 0, 0, 0, -3 * DEG,
                       -2 * DEG, -2 * DEG));
    send(make_collider(1, 32'd41, 5 * DEG, -3 * DEG, 2 * DEG, 32'd32768, 359 * DEG,
                       180 * DEG, 0, 0, 0));

    set_query(32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send(make_collider(0, 32'd44, 0, 0, 0, 0, 0, 0, DEG, 0, 0));
    set_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(make_collider(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, DEG, 0, 0));
    send(make_collider(1, 32'd45, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send(make_collider(0, 32'd46, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0,
                       32'h8000_0000, 0, 0));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      set_query($signed($urandom_range(1 << 24)) - (1 << 23),
                $signed($urandom_range(1 << 24)) - (1 << 23),
                (ph == 5) ? 32'h8000_0000 : $signed($urandom_range(1 << 24)) - (1 << 23),
                (ph == 6) ? 31'h7FFF_FFFF : 31'($urandom_range(16 << 16)),
                (ph == 3) ? 32'hFFFF_FFFF : ($urandom | $urandom),
                (ph == 0) ? 32'd0 : $urandom);
      repeat (75) begin
        c = random_collider();
        send(c);
      end
    end
    in_valid <= 1'b0;
    drain_pipe();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
src/sof_pkg.sv
src/sof_angle.sv
src/sof_rot.sv
src/sof_sphere.sv
src/sof_box.sv
src/sphere_overlap_filter_top.sv
sim/sof_checker.sv
sim/sphere_overlap_filter_top_tb.sv
